[rtl/park_rotation_transform_top_macros.svh]
// Assertion helpers for the park rotation block.
// Clock is clk, reset is rst; both are taken from the including module.
`ifndef PARK_ROTATION_TRANSFORM_TOP_MACROS_SVH
`define PARK_ROTATION_TRANSFORM_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define PRT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define PRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PRT_ASSERT_IMPL(label, ante, cons, msg)
`define PRT_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[rtl/prt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package prt_pkg;

  localparam int ANGLE_W        = 11;
  localparam int TABLE_W        = 16;
  localparam int FRAC_BITS      = 15;
  localparam int ROUND_BIAS     = 16384;
  localparam int MIN_TABLE_LOG2 = 6;
  // restoring steps needed to fold an ANGLE_W index into the smallest table
  localparam int FOLD_STEPS     = ANGLE_W - MIN_TABLE_LOG2;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint          Q15_MAX     = 64'sd32767;

  localparam logic FUNC_FORWARD = 1'b0;
  localparam logic FUNC_INVERSE = 1'b1;

  typedef struct packed {
    logic rom;
    logic mul;
    logic sum;
    logic out;
  } stage_en_t;

  // First-quadrant sine, x in Q30 radians; seven Taylor terms, result Q15.
  // Only evaluated at elaboration to build the table.
  function automatic logic [TABLE_W-1:0] quarter_sine(input longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    longint          acc;
    x2  = (x * x) >> 30;
    t   = x;
    acc = longint'(x);
    t   = ((t * x2) >> 30) / 6;
    acc = acc - longint'(t);
    t   = ((t * x2) >> 30) / 20;
    acc = acc + longint'(t);
    t   = ((t * x2) >> 30) / 42;
    acc = acc - longint'(t);
    t   = ((t * x2) >> 30) / 72;
    acc = acc + longint'(t);
    t   = ((t * x2) >> 30) / 110;
    acc = acc - longint'(t);
    t   = ((t * x2) >> 30) / 156;
    acc = acc + longint'(t);
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc + 64'sd16384) >>> 15;
    if (acc > Q15_MAX) begin
      acc = Q15_MAX;
    end
    return TABLE_W'(acc);
  endfunction

endpackage
`default_nettype wire

[rtl/prt_index.sv]
`timescale 1ns / 1ps
`default_nettype none
// Stage 1: fold the angle into the table and form the cosine index.
module prt_index #(
  parameter int TABLE_SIZE   = 2048,
  parameter int QUARTER_TURN = 512,
  parameter int SAMPLE_WIDTH = 16,
  parameter int IDX_W        = 11
) (
  input  wire logic                                   clk,
  input  wire logic                                   en,
  input  wire logic                                   func,
  input  wire logic signed [SAMPLE_WIDTH-1:0]         in_x,
  input  wire logic signed [SAMPLE_WIDTH-1:0]         in_y,
  input  wire logic        [prt_pkg::ANGLE_W-1:0]     angle,
  output logic             [IDX_W-1:0]                sin_idx,
  output logic             [IDX_W-1:0]                cos_idx,
  output logic                                        func_q,
  output logic signed      [SAMPLE_WIDTH-1:0]         x_q,
  output logic signed      [SAMPLE_WIDTH-1:0]         y_q
);

  localparam int CW     = IDX_W + 1;
  localparam int QT_MOD = QUARTER_TURN % TABLE_SIZE;

  logic [prt_pkg::ANGLE_W-1:0] folded;
  logic [IDX_W-1:0]            sin_idx_next;
  logic [CW-1:0]               cos_sum;
  logic [IDX_W-1:0]            cos_idx_next;

  always_comb begin
    folded = angle;
    for (int k = prt_pkg::FOLD_STEPS - 1; k >= 0; k--) begin
      if (longint'(folded) >= (longint'(TABLE_SIZE) << k)) begin
        folded = folded - prt_pkg::ANGLE_W'(longint'(TABLE_SIZE) << k);
      end
    end
    sin_idx_next = IDX_W'(folded);
    cos_sum      = CW'(sin_idx_next) + CW'(QT_MOD);
    if (cos_sum >= CW'(TABLE_SIZE)) begin
      cos_sum = cos_sum - CW'(TABLE_SIZE);
    end
    cos_idx_next = IDX_W'(cos_sum);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_idx <= sin_idx_next;
      cos_idx <= cos_idx_next;
      func_q  <= func;
      x_q     <= in_x;
      y_q     <= in_y;
    end
  end

endmodule
`default_nettype wire

[rtl/prt_sine_rom.sv]
`timescale 1ns / 1ps
`default_nettype none
// Full-turn sine table, built at elaboration; two registered read ports.
module prt_sine_rom #(
  parameter int TABLE_SIZE = 2048,
  parameter int IDX_W      = 11
) (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic        [IDX_W-1:0]              sin_idx,
  input  wire logic        [IDX_W-1:0]              cos_idx,
  output logic signed      [prt_pkg::TABLE_W-1:0]   sin_val,
  output logic signed      [prt_pkg::TABLE_W-1:0]   cos_val
);

  logic signed [prt_pkg::TABLE_W-1:0] rom_data [TABLE_SIZE];

  for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_entry
    localparam longint unsigned FOUR = 64'(4 * i);
    localparam longint unsigned QUAD = FOUR / TABLE_SIZE;
    localparam longint unsigned REM  = FOUR - QUAD * TABLE_SIZE;
    // mirror odd quadrants
    localparam longint unsigned R    = (QUAD % 2 == 1) ? TABLE_SIZE - REM : REM;
    localparam longint unsigned X    = (R * prt_pkg::HALF_PI_Q30) / TABLE_SIZE;
    localparam logic signed [prt_pkg::TABLE_W-1:0] MAG = prt_pkg::quarter_sine(X);
    assign rom_data[i] = (QUAD >= 2) ? -MAG : MAG;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_val <= rom_data[sin_idx];
      cos_val <= rom_data[cos_idx];
    end
  end

endmodule
`default_nettype wire

[rtl/prt_rotate.sv]
`timescale 1ns / 1ps
`default_nettype none
// Stages 2..5: operand align, products, rounded sums, saturation.
module prt_rotate #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                                 clk,
  input  wire prt_pkg::stage_en_t                   en,
  input  wire logic                                 func,
  input  wire logic signed [SAMPLE_WIDTH-1:0]       in_x,
  input  wire logic signed [SAMPLE_WIDTH-1:0]       in_y,
  input  wire logic signed [prt_pkg::TABLE_W-1:0]   sin_val,
  input  wire logic signed [prt_pkg::TABLE_W-1:0]   cos_val,
  output logic signed      [SAMPLE_WIDTH-1:0]       out_x,
  output logic signed      [SAMPLE_WIDTH-1:0]       out_y,
  output logic                                      clipped
);

  localparam int PROD_W = prt_pkg::TABLE_W + SAMPLE_WIDTH;
  localparam int SUM_W  = PROD_W + 2;
  localparam logic signed [SUM_W-1:0] SAT_HI =
    SUM_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] BIAS   = SUM_W'(prt_pkg::ROUND_BIAS);

  // stage 2: operands wait for the table read
  logic                           func_r;
  logic signed [SAMPLE_WIDTH-1:0] x_r;
  logic signed [SAMPLE_WIDTH-1:0] y_r;

  // stage 3: products
  logic                           func_m;
  logic signed [PROD_W-1:0]       prod_cx;
  logic signed [PROD_W-1:0]       prod_sy;
  logic signed [PROD_W-1:0]       prod_sx;
  logic signed [PROD_W-1:0]       prod_cy;

  // stage 4: sums with rounding bias
  logic signed [SUM_W-1:0]        sum_x;
  logic signed [SUM_W-1:0]        sum_y;
  logic signed [SUM_W-1:0]        sum_x_next;
  logic signed [SUM_W-1:0]        sum_y_next;

  // stage 5: shift and clamp
  logic signed [SUM_W-1:0]        shx;
  logic signed [SUM_W-1:0]        shy;
  logic signed [SAMPLE_WIDTH-1:0] out_x_next;
  logic signed [SAMPLE_WIDTH-1:0] out_y_next;
  logic                           clip_x;
  logic                           clip_y;

  always_ff @(posedge clk) begin
    if (en.rom) begin
      func_r <= func;
      x_r    <= in_x;
      y_r    <= in_y;
    end
    if (en.mul) begin
      func_m  <= func_r;
      prod_cx <= PROD_W'(cos_val) * PROD_W'(x_r);
      prod_sy <= PROD_W'(sin_val) * PROD_W'(y_r);
      prod_sx <= PROD_W'(sin_val) * PROD_W'(x_r);
      prod_cy <= PROD_W'(cos_val) * PROD_W'(y_r);
    end
    if (en.sum) begin
      sum_x <= sum_x_next;
      sum_y <= sum_y_next;
    end
    if (en.out) begin
      out_x   <= out_x_next;
      out_y   <= out_y_next;
      clipped <= clip_x | clip_y;
    end
  end

  always_comb begin
    case (func_m)
      prt_pkg::FUNC_FORWARD: begin
        sum_x_next = SUM_W'(prod_cx) + SUM_W'(prod_sy) + BIAS;
        sum_y_next = SUM_W'(prod_cy) - SUM_W'(prod_sx) + BIAS;
      end
      prt_pkg::FUNC_INVERSE: begin
        sum_x_next = SUM_W'(prod_cx) - SUM_W'(prod_sy) + BIAS;
        sum_y_next = SUM_W'(prod_sx) + SUM_W'(prod_cy) + BIAS;
      end
      default: begin
        sum_x_next = '0;
        sum_y_next = '0;
      end
    endcase
  end

  always_comb begin
    shx    = sum_x >>> prt_pkg::FRAC_BITS;
    shy    = sum_y >>> prt_pkg::FRAC_BITS;
    clip_x = 1'b0;
    clip_y = 1'b0;
    if (shx > SAT_HI) begin
      out_x_next = SAMPLE_WIDTH'(SAT_HI);
      clip_x     = 1'b1;
    end else if (shx < SAT_LO) begin
      out_x_next = SAMPLE_WIDTH'(SAT_LO);
      clip_x     = 1'b1;
    end else begin
      out_x_next = SAMPLE_WIDTH'(shx);
    end
    if (shy > SAT_HI) begin
      out_y_next = SAMPLE_WIDTH'(SAT_HI);
      clip_y     = 1'b1;
    end else if (shy < SAT_LO) begin
      out_y_next = SAMPLE_WIDTH'(SAT_LO);
      clip_y     = 1'b1;
    end else begin
      out_y_next = SAMPLE_WIDTH'(shy);
    end
  end

endmodule
`default_nettype wire

[rtl/park_rotation_transform_top.sv]
//  channel   direction  handshake              payload
//  request   in         in_valid / in_stall    func, in_x, in_y, angle
//  result    out        out_valid / out_stall  out_x, out_y, clipped
//
//  One request per clock, sustained while out_stall is low.
//  Five register stages: index fold, table read, products, rounded sums, clamp.
//  The two table read ports and the four multipliers each take one stage.
//  rst is synchronous, active high; it empties every stage, the table needs no fill.
//  A stall holds only the stages that are full; bubbles ahead of it still close up.
`timescale 1ns / 1ps
`default_nettype none
`include "park_rotation_transform_top_macros.svh"
module park_rotation_transform_top #(
  parameter int TABLE_SIZE   = 2048,
  parameter int QUARTER_TURN = 512,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               func,
  input  wire logic signed [SAMPLE_WIDTH-1:0]     in_x,
  input  wire logic signed [SAMPLE_WIDTH-1:0]     in_y,
  input  wire logic        [prt_pkg::ANGLE_W-1:0] angle,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed      [SAMPLE_WIDTH-1:0]     out_x,
  output logic signed      [SAMPLE_WIDTH-1:0]     out_y,
  output logic                                    clipped
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // per-stage occupancy
  logic idx_valid;
  logic rom_valid;
  logic mul_valid;
  logic sum_valid;

  // a stage may load when it is empty or its contents move on
  logic idx_ready;
  logic rom_ready;
  logic mul_ready;
  logic sum_ready;
  logic out_ready;

  prt_pkg::stage_en_t en;

  logic [IDX_W-1:0]                   sin_idx;
  logic [IDX_W-1:0]                   cos_idx;
  logic                               func_q;
  logic signed [SAMPLE_WIDTH-1:0]     x_q;
  logic signed [SAMPLE_WIDTH-1:0]     y_q;
  logic signed [prt_pkg::TABLE_W-1:0] sin_val;
  logic signed [prt_pkg::TABLE_W-1:0] cos_val;

  always_comb begin
    out_ready = !out_valid || !out_stall;
    sum_ready = !sum_valid || out_ready;
    mul_ready = !mul_valid || sum_ready;
    rom_ready = !rom_valid || mul_ready;
    idx_ready = !idx_valid || rom_ready;
    in_stall  = !idx_ready;
    en.rom    = rom_ready;
    en.mul    = mul_ready;
    en.sum    = sum_ready;
    en.out    = out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx_valid <= 1'b0;
      rom_valid <= 1'b0;
      mul_valid <= 1'b0;
      sum_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (idx_ready) begin
        idx_valid <= in_valid;
      end
      if (rom_ready) begin
        rom_valid <= idx_valid;
      end
      if (mul_ready) begin
        mul_valid <= rom_valid;
      end
      if (sum_ready) begin
        sum_valid <= mul_valid;
      end
      if (out_ready) begin
        out_valid <= sum_valid;
      end
    end
  end

  // stage 1: angle fold, cosine index
  prt_index #(
    .TABLE_SIZE   (TABLE_SIZE),
    .QUARTER_TURN (QUARTER_TURN),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .IDX_W        (IDX_W)
  ) u_index (
    .clk     (clk),
    .en      (idx_ready),
    .func    (func),
    .in_x    (in_x),
    .in_y    (in_y),
    .angle   (angle),
    .sin_idx (sin_idx),
    .cos_idx (cos_idx),
    .func_q  (func_q),
    .x_q     (x_q),
    .y_q     (y_q)
  );

  // stage 2: sine and cosine lookup
  prt_sine_rom #(
    .TABLE_SIZE (TABLE_SIZE),
    .IDX_W      (IDX_W)
  ) u_sine_rom (
    .clk     (clk),
    .en      (rom_ready),
    .sin_idx (sin_idx),
    .cos_idx (cos_idx),
    .sin_val (sin_val),
    .cos_val (cos_val)
  );

  // stages 2..5: rotation arithmetic and output register
  prt_rotate #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_rotate (
    .clk     (clk),
    .en      (en),
    .func    (func_q),
    .in_x    (x_q),
    .in_y    (y_q),
    .sin_val (sin_val),
    .cos_val (cos_val),
    .out_x   (out_x),
    .out_y   (out_y),
    .clipped (clipped)
  );

  // an accepted request always lands in the first stage
  `PRT_ASSERT_NEXT(a_accept_lands, in_valid && !in_stall, idx_valid, "request lost at entry")
  // an empty first stage never pushes back
  `PRT_ASSERT_IMPL(a_empty_no_stall, !idx_valid, !in_stall, "stall with empty entry stage")
  // a held result keeps the full stage behind it full
  `PRT_ASSERT_NEXT(a_sum_held, out_valid && out_stall && sum_valid, sum_valid,
                   "sum stage dropped under stall")
  // a taken result with nothing behind it leaves the output empty
  `PRT_ASSERT_NEXT(a_drain, out_valid && !out_stall && !sum_valid, !out_valid,
                   "result repeated")
  // the clip flag only comes with a value at a rail
  `PRT_ASSERT_IMPL(a_clip_rail, out_valid && clipped,
                   out_x == SAT_MAX || out_x == SAT_MIN || out_y == SAT_MAX || out_y == SAT_MIN,
                   "clip flag without saturated output")

endmodule
`default_nettype wire
